FILE: sv/apes_pkg.sv
// ---------------------------------------------------------------------------
// apes_pkg: shared types and constants
// Fixed-point constants, CORDIC arctangent table and the cell word layout.
// ---------------------------------------------------------------------------
`default_nettype none

package apes_pkg;

    // chain geometry
    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 32;
    localparam int CELL_COUNT    = SQRT_STEPS;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOBILITY  = 2'd1;

    localparam logic [31:0] TIME_STEP_RESET = 32'd42949673;
    localparam logic [31:0] MOBILITY_RESET  = 32'd65536;

    // angle constants, Q2.30 for the rotator
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

    // heading wrap constants, Q3.29
    localparam logic [43:0] PI_Q29      = 44'd1686629713;
    localparam logic [43:0] TWO_PI_Q29  = 44'd3373259426;
    localparam logic [43:0] WRAP_OFFSET = PI_Q29 + 44'd2048 * TWO_PI_Q29;
    // 2^48 / TWO_PI_Q29 (that is 2^19 / 2pi), for the quotient estimate
    localparam logic [16:0] WRAP_RECIP  = 17'((64'd1 << 48) / 64'd3373259426);

    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
        31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
        31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
        31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
        31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F, 31'h0000003F,
        31'h0000001F, 31'h0000000F, 31'h00000008, 31'h00000004, 31'h00000002,
        31'h00000001, 31'h00000000
    };

    // word handed from cell to cell
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
        logic [63:0]        rad;
        logic [63:0]        root;
        logic [31:0]        v0;
        logic signed [48:0] t2x;
        logic signed [48:0] t2y;
        logic signed [31:0] heading;
        logic signed [15:0] noise;
        logic               last;
    } apes_cell_t;

    // per-cell constants
    typedef struct packed {
        logic        rot;
        logic [4:0]  shift;
        logic [30:0] atan;
        logic [63:0] sq_bit;
    } apes_step_t;

    typedef struct packed {
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] heading_out;
        logic               end_of_step;
    } apes_result_t;

endpackage

`default_nettype wire

FILE: sv/apes_if.sv
// ---------------------------------------------------------------------------
// apes_if: channel interfaces
// Particle input, result output and configuration write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface apes_particle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [31:0]        propulsion_speed;
    logic [31:0]        rotational_diffusion;
    logic signed [31:0] heading_in;
    logic signed [15:0] noise_sample;
    logic               last_particle;

    modport source (output valid, force_x, force_y, propulsion_speed,
                    rotational_diffusion, heading_in, noise_sample,
                    last_particle, input ready);
    modport sink   (input valid, force_x, force_y, propulsion_speed,
                    rotational_diffusion, heading_in, noise_sample,
                    last_particle, output ready);
endinterface

interface apes_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] heading_out;
    logic               end_of_step;

    modport source (output valid, disp_x, disp_y, heading_out, end_of_step,
                    input ready);
    modport sink   (input valid, disp_x, disp_y, heading_out, end_of_step,
                    output ready);
endinterface

interface apes_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/active_particle_euler_step.sv
// ---------------------------------------------------------------------------
// active_particle_euler_step: active Brownian particle Euler-Maruyama step
// One particle word in, one displacement/heading word out.
// ---------------------------------------------------------------------------
// Usage:
//   particle: valid/ready input channel, one word per particle (forces,
//             speed, rotational diffusion, heading, noise, end mark).
//   result:   valid/ready output channel, one word per particle, same order.
//   cfg:      valid/ready write channel; index 0 = time_step, 1 = mobility,
//             other indexes ignored. Write only while no particle is in flight.
// The result path is 38 registers: one input stage, a chain of 32 cells
// (each does one CORDIC rotation and one square root bit, the rotation
// idle past the 24th cell) and five back-end stages.
// Throughput is one word per cycle; the whole pipeline advances together
// whenever the output register is empty or being taken.
// When the receiver stalls, the pipeline holds and particle.ready drops,
// so words wait in place and none are lost.
// Reset clears all valid bits and loads time_step = 42949673 and
// mobility = 65536; cfg.ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module active_particle_euler_step (
    input  wire logic   clk,
    input  wire logic   rst_n,
    apes_particle_if.sink particle,
    apes_result_if.source result,
    apes_cfg_if.sink      cfg
);
    import apes_pkg::*;

    logic [31:0] time_step_reg;
    logic [31:0] mobility_reg;
    logic        adv;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
            mobility_reg  <= MOBILITY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TIME_STEP: time_step_reg <= cfg.data;
                REG_MOBILITY:  mobility_reg  <= cfg.data;
                default:       ;
            endcase
        end
    end

    // global advance
    logic         tail_valid;
    apes_result_t tail_res;

    assign adv            = !tail_valid || result.ready;
    assign particle.ready = adv;

    // input stage: products, angle fold
    logic [63:0]        dtdr;
    logic signed [64:0] pmx, pmy;
    logic signed [33:0] z0;
    apes_cell_t         front_next;
    logic               front_valid_reg;
    apes_cell_t         front_reg;

    assign dtdr = time_step_reg * particle.rotational_diffusion;
    assign pmx  = $signed({1'b0, mobility_reg}) * particle.force_x;
    assign pmy  = $signed({1'b0, mobility_reg}) * particle.force_y;
    assign z0   = {particle.heading_in[31], particle.heading_in, 1'b0};

    always_comb
    begin
        front_next         = '0;
        front_next.x       = CORDIC_GAIN;
        front_next.y       = '0;
        front_next.z       = z0;
        front_next.flip    = 1'b0;
        if (z0 > HALF_PI_Q30)
        begin
            front_next.z    = z0 - PI_Q30;
            front_next.flip = 1'b1;
        end
        else if (z0 < -HALF_PI_Q30)
        begin
            front_next.z    = z0 + PI_Q30;
            front_next.flip = 1'b1;
        end
        front_next.rad     = {7'd0, dtdr[63:8], 1'b0};
        front_next.root    = '0;
        front_next.v0      = particle.propulsion_speed;
        front_next.t2x     = pmx[64:16];
        front_next.t2y     = pmy[64:16];
        front_next.heading = particle.heading_in;
        front_next.noise   = particle.noise_sample;
        front_next.last    = particle.last_particle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (adv)
            front_valid_reg <= particle.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            front_reg <= front_next;
    end

    // chain of cells
    logic       chain_valid [CELL_COUNT+1];
    apes_cell_t chain_word  [CELL_COUNT+1];

    assign chain_valid[0] = front_valid_reg;
    assign chain_word[0]  = front_reg;

    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        apes_step_t step;
        assign step.rot    = (i < CORDIC_STAGES);
        assign step.shift  = 5'(i);
        assign step.atan   = ATAN_Q30[i];
        assign step.sq_bit = 64'd1 << (62 - 2 * i);

        apes_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .step      (step),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    // back end
    apes_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .time_step (time_step_reg),
        .in_valid  (chain_valid[CELL_COUNT]),
        .in_word   (chain_word[CELL_COUNT]),
        .out_valid (tail_valid),
        .result    (tail_res)
    );

    assign result.valid       = tail_valid;
    assign result.disp_x      = tail_res.disp_x;
    assign result.disp_y      = tail_res.disp_y;
    assign result.heading_out = tail_res.heading_out;
    assign result.end_of_step = tail_res.end_of_step;

endmodule

`default_nettype wire

FILE: sv/apes_cell.sv
// ---------------------------------------------------------------------------
// apes_cell: one link of the chain
// One CORDIC rotation step (when step.rot is set) and one integer square root step per cell.
// ---------------------------------------------------------------------------
`default_nettype none

module apes_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire apes_pkg::apes_step_t step,
    input  wire logic                in_valid,
    input  wire apes_pkg::apes_cell_t in_word,
    output logic                     out_valid,
    output apes_pkg::apes_cell_t     out_word
);
    import apes_pkg::*;

    logic                 valid_reg;
    apes_cell_t           word_reg;
    apes_cell_t           word_next;
    logic signed [33:0]   dx;
    logic signed [33:0]   dy;
    logic signed [33:0]   at;
    logic [63:0]          trial;

    // rotation and root step
    always_comb
    begin
        word_next = in_word;
        dx        = in_word.y >>> step.shift;
        dy        = in_word.x >>> step.shift;
        at        = $signed({3'b000, step.atan});
        trial     = in_word.root + step.sq_bit;
        if (step.rot)
        begin
            if (!in_word.z[33])
            begin
                word_next.x = in_word.x - dx;
                word_next.y = in_word.y + dy;
                word_next.z = in_word.z - at;
            end
            else
            begin
                word_next.x = in_word.x + dx;
                word_next.y = in_word.y - dy;
                word_next.z = in_word.z + at;
            end
        end
        if (in_word.rad >= trial)
        begin
            word_next.rad  = in_word.rad - trial;
            word_next.root = (in_word.root >> 1) + step.sq_bit;
        end
        else
        begin
            word_next.root = in_word.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

FILE: sv/apes_tail.sv
// ---------------------------------------------------------------------------
// apes_tail: displacement and heading back end
// Scales by speed, adds mobility term, multiplies by dt, wraps the heading.
// ---------------------------------------------------------------------------
`default_nettype none

module apes_tail (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [31:0]         time_step,
    input  wire logic                in_valid,
    input  wire apes_pkg::apes_cell_t in_word,
    output logic                     out_valid,
    output apes_pkg::apes_result_t   result
);
    import apes_pkg::*;

    logic [4:0] valid_reg;

    // stage 1: speed and noise products
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
    logic signed [66:0] pcx_reg, pcy_reg;
    logic signed [45:0] pinc_reg;
    logic signed [48:0] t2x_reg, t2y_reg;
    logic signed [31:0] head1_reg;
    logic               last1_reg;

    assign cos_v = in_word.flip ? -in_word.x : in_word.x;
    assign sin_v = in_word.flip ? -in_word.y : in_word.y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcx_reg   <= $signed({1'b0, in_word.v0}) * cos_v;
            pcy_reg   <= $signed({1'b0, in_word.v0}) * sin_v;
            pinc_reg  <= $signed({1'b0, in_word.root[28:0]}) * in_word.noise;
            t2x_reg   <= in_word.t2x;
            t2y_reg   <= in_word.t2y;
            head1_reg <= in_word.heading;
            last1_reg <= in_word.last;
        end
    end

    // stage 2: sums, magnitudes, offset heading
    logic signed [49:0] sumx, sumy;
    logic [49:0]        magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic [43:0]        u2_reg;
    logic               last2_reg;

    assign sumx = 50'(pcx_reg >>> 30) + 50'(t2x_reg);
    assign sumy = 50'(pcy_reg >>> 30) + 50'(t2y_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negx_reg  <= sumx[49];
            negy_reg  <= sumy[49];
            magx_reg  <= sumx[49] ? 50'(-sumx) : 50'(sumx);
            magy_reg  <= sumy[49] ? 50'(-sumy) : 50'(sumy);
            u2_reg    <= 44'(head1_reg) + 44'(pinc_reg >>> 3) + WRAP_OFFSET;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: dt partial products, wrap quotient estimate
    logic [36:0] qprod;
    logic [57:0] ax_reg, ay_reg;
    logic [55:0] bx_reg, by_reg;
    logic [12:0] qe_reg;
    logic [43:0] u3_reg;
    logic        negx3_reg, negy3_reg, last3_reg;

    assign qprod = u2_reg[43:24] * WRAP_RECIP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg    <= magx_reg[49:24] * time_step;
            bx_reg    <= magx_reg[23:0] * time_step;
            ay_reg    <= magy_reg[49:24] * time_step;
            by_reg    <= magy_reg[23:0] * time_step;
            qe_reg    <= qprod[36:24];
            u3_reg    <= u2_reg;
            negx3_reg <= negx_reg;
            negy3_reg <= negy_reg;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: combine partials, remainder
    logic [81:0] fullx, fully;
    logic [43:0] qmul;
    logic [43:0] remw;
    logic [49:0] qx_reg, qy_reg;
    logic [33:0] rem_reg;
    logic        negx4_reg, negy4_reg, last4_reg;

    assign fullx = {ax_reg, 24'd0} + {26'd0, bx_reg};
    assign fully = {ay_reg, 24'd0} + {26'd0, by_reg};
    assign qmul  = qe_reg * TWO_PI_Q29;
    assign remw  = u3_reg - qmul;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg    <= fullx[81:32];
            qy_reg    <= fully[81:32];
            rem_reg   <= remw[33:0];
            negx4_reg <= negx3_reg;
            negy4_reg <= negy3_reg;
            last4_reg <= last3_reg;
        end
    end

    // stage 5: saturate, final wrap correction
    function automatic logic signed [31:0] sat(input logic neg, input logic [49:0] q);
        logic signed [31:0] r;
        if (neg)
            r = (q > 50'd2147483648) ? 32'sh80000000 : $signed(32'(-q));
        else
            r = (q > 50'd2147483647) ? 32'sh7FFFFFFF : $signed(q[31:0]);
        return r;
    endfunction

    logic [33:0]  m;
    logic [33:0]  h;
    apes_result_t res_reg;

    assign m = (rem_reg >= TWO_PI_Q29[33:0]) ? rem_reg - TWO_PI_Q29[33:0] : rem_reg;
    assign h = m - PI_Q29[33:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.disp_x      <= sat(negx4_reg, qx_reg);
            res_reg.disp_y      <= sat(negy4_reg, qy_reg);
            res_reg.heading_out <= $signed(h[31:0]);
            res_reg.end_of_step <= last4_reg;
        end
    end

    // valid shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    assign out_valid = valid_reg[4];
    assign result    = res_reg;

endmodule

`default_nettype wire

FILE: tb/sv/particle_step_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_step_checker: scoreboard for the active particle Euler step
// Watches the particle, result and configuration channels, predicts each
// result word from the accepted particle and the current registers, and
// compares every field of the returned word in order.
// ---------------------------------------------------------------------------

module particle_step_checker (
    input  logic      clk,
    input  logic      rst_n,
    apes_particle_if  particle,
    apes_result_if    result,
    apes_cfg_if       cfg,
    output int        mismatches,
    output int        in_flight,
    output int        words_checked
);
    import apes_pkg::*;

    logic [31:0]  dt_q32;
    logic [31:0]  mob_q16;
    apes_result_t pending_steps[$];

    // rotation-mode CORDIC on a Q2.30 angle, folded by pi when outside +-pi/2
    function automatic void rotate_heading(input longint angle, output longint cos_v,
                                           output longint sin_v);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     mirrored;
        x = CORDIC_GAIN;
        y = 0;
        z = angle;
        mirrored = 1'b0;
        if (z > HALF_PI_Q30)
        begin
            z -= PI_Q30;
            mirrored = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z += PI_Q30;
            mirrored = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_Q30[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_Q30[i]);
            end
        end
        cos_v = mirrored ? -x : x;
        sin_v = mirrored ? -y : y;
    endfunction

    // bitwise integer square root, 32 iterations
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // dt * (v0 * trig + mobility * force), truncated toward zero, saturated
    function automatic logic [31:0] scaled_disp(input longint trig, input longint force_v,
                                                input logic [31:0] v0);
        longint          t1;
        longint          t2;
        longint          sum;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned b;
        longint unsigned q;
        longint unsigned dt64;
        t1   = (longint'({32'b0, v0}) * trig) >>> 30;
        t2   = (longint'({32'b0, mob_q16}) * force_v) >>> 16;
        sum  = t1 + t2;
        mag  = (sum < 0) ? longint'(-sum) : sum;
        dt64 = {32'b0, dt_q32};
        a    = (mag >> 24) * dt64;
        b    = (mag & 64'hFF_FFFF) * dt64;
        q    = (a >> 8) + ((((a & 64'hFF) << 24) + b) >> 32);
        if (sum < 0)
            return (q > 64'd2147483648) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'd2147483647) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic apes_result_t predict_step();
        apes_result_t    r;
        longint          hdg;
        longint          c;
        longint          s;
        longint unsigned sigma;
        longint          incr;
        longint          m;
        hdg = longint'(particle.heading_in);
        rotate_heading(hdg * 2, c, s);
        r.disp_x = scaled_disp(c, longint'(particle.force_x), particle.propulsion_speed);
        r.disp_y = scaled_disp(s, longint'(particle.force_y), particle.propulsion_speed);
        sigma = root64((({32'b0, dt_q32} * {32'b0, particle.rotational_diffusion}) >> 8) << 1);
        incr  = (longint'(sigma) * longint'(particle.noise_sample)) >>> 3;
        m = (hdg + incr + longint'(PI_Q29)) % longint'(TWO_PI_Q29);
        if (m < 0)
            m += longint'(TWO_PI_Q29);
        r.heading_out = 32'(m - longint'(PI_Q29));
        r.end_of_step = particle.last_particle;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("[%0t] %s: got %0d (0x%08h), want %0d (0x%08h)", $realtime, what,
                     $signed(got), got, $signed(want), want);
    endtask

    // registers follow every accepted configuration word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_q32  <= TIME_STEP_RESET;
            mob_q16 <= MOBILITY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_TIME_STEP)
                dt_q32 <= cfg.data;
            else if (cfg.index == REG_MOBILITY)
                mob_q16 <= cfg.data;
        end
    end

    // predict on particle accept, compare on result accept
    always @(posedge clk or negedge rst_n)
    begin
        apes_result_t want;
        if (!rst_n)
        begin
            pending_steps.delete();
            mismatches    = 0;
            in_flight     = 0;
            words_checked = 0;
        end
        else
        begin
            if (particle.valid && particle.ready)
                pending_steps.push_back(predict_step());
            if (result.valid && result.ready)
            begin
                words_checked++;
                if (pending_steps.size() == 0)
                    report_mismatch("result word with nothing expected", 0, 0);
                else
                begin
                    want = pending_steps.pop_front();
                    if (result.disp_x !== want.disp_x)
                        report_mismatch("disp_x", result.disp_x, want.disp_x);
                    if (result.disp_y !== want.disp_y)
                        report_mismatch("disp_y", result.disp_y, want.disp_y);
                    if (result.heading_out !== want.heading_out)
                        report_mismatch("heading_out", result.heading_out, want.heading_out);
                    if (result.end_of_step !== want.end_of_step)
                        report_mismatch("end_of_step", 32'(result.end_of_step),
                                        32'(want.end_of_step));
                end
            end
            in_flight = pending_steps.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for active_particle_euler_step
// Runs directed corner particles, then random particles over four idle and
// stall patterns and several register settings, with one long receiver
// hold-off; the checker beside the block does all the comparing.
// ---------------------------------------------------------------------------

module tb;
    import apes_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int RANDOM_PER_PHASE = 208;
    localparam int DRAIN_CYCLES     = 60;
    localparam int IDLE_LIMIT       = 5000;
    localparam int HOLD_CYCLES      = 300;
    localparam logic signed [31:0] PI_HDG = 32'sd1686629713;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  idle_count = 0;
    int  mismatches;
    int  in_flight;
    int  words_checked;
    int  particles_sent = 0;

    apes_particle_if particle ();
    apes_result_if   result ();
    apes_cfg_if      cfg ();

    active_particle_euler_step dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle),
        .result   (result),
        .cfg      (cfg)
    );

    particle_step_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .particle      (particle),
        .result        (result),
        .cfg           (cfg),
        .mismatches    (mismatches),
        .in_flight     (in_flight),
        .words_checked (words_checked)
    );

    always #1 clk = ~clk;

    initial
    begin
        particle.valid = 1'b0;
        particle.force_x = '0;
        particle.force_y = '0;
        particle.propulsion_speed = '0;
        particle.rotational_diffusion = '0;
        particle.heading_in = '0;
        particle.noise_sample = '0;
        particle.last_particle = 1'b0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
    end

    // watchdog: cycles with no word accepted on any channel
    always @(posedge clk)
    begin
        if ((particle.valid && particle.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == IDLE_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // each cycle before an offer is idle with probability send_idle_pct
    task automatic send_particle(input logic [31:0] fx, input logic [31:0] fy,
                                 input logic [31:0] v0, input logic [31:0] dr,
                                 input logic [31:0] hdg, input logic [15:0] noise,
                                 input logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            particle.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        particle.valid                <= 1'b1;
        particle.force_x              <= fx;
        particle.force_y              <= fy;
        particle.propulsion_speed     <= v0;
        particle.rotational_diffusion <= dr;
        particle.heading_in           <= hdg;
        particle.noise_sample         <= noise;
        particle.last_particle        <= last;
        @(posedge clk);
        while (!particle.ready)
            @(posedge clk);
        particles_sent++;
    endtask

    task automatic random_particle();
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] v0;
        logic [31:0] dr;
        logic [31:0] hdg;
        fx  = $urandom;
        fy  = $urandom;
        v0  = $urandom;
        dr  = $urandom;
        hdg = $urandom;
        // mostly physical magnitudes, some full-range words
        if ($urandom_range(3) != 0)
        begin
            fx = 32'($signed(fx) >>> $urandom_range(24, 8));
            fy = 32'($signed(fy) >>> $urandom_range(24, 8));
            v0 = v0 >> $urandom_range(24, 8);
            dr = dr >> $urandom_range(24, 4);
        end
        if ($urandom_range(4) != 0)
            hdg = 32'($signed($urandom_range(2 * PI_HDG)) - PI_HDG);
        send_particle(fx, fy, v0, dr, hdg, 16'($urandom), ($urandom_range(9) == 0));
    endtask

    // configuration writes happen only with the pipeline empty;
    // valid stays high across consecutive writes
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic settle_and_configure(input logic [31:0] dt, input logic [31:0] mob);
        particle.valid <= 1'b0;
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_register(REG_TIME_STEP, dt);
        write_register(REG_MOBILITY, mob);
        write_register(REG_SPARE, $urandom);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        int n;
        int phase_idle;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under reset registers
        send_particle(0, 0, 0, 0, 0, 0, 1'b0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      PI_HDG, 16'h7FFF, 1'b1);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      -PI_HDG, 16'h8000, 1'b0);
        send_particle(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h8000_0000, 16'h1000, 1'b1);
        send_particle(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                      32'h7FFF_FFFF, 16'hF000, 1'b0);
        send_particle(0, 0, 32'h0001_0000, 0, PI_HDG / 2, 0, 1'b0);
        send_particle(0, 0, 32'h0001_0000, 0, -PI_HDG / 2, 0, 1'b0);
        send_particle(0, 0, 32'h0001_0000, 0, PI_HDG / 2 + 1, 0, 1'b0);
        send_particle(0, 0, 32'h0001_0000, 0, -PI_HDG / 2 - 1, 0, 1'b0);
        send_particle(0, 0, 32'h0001_0000, 32'h0001_0000, PI_HDG - 1, 16'h7FFF, 1'b0);
        send_particle(0, 0, 32'h0001_0000, 32'h0001_0000, -PI_HDG, 16'h8000, 1'b1);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 16'h8000, 1'b0);
        send_particle(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                      1, 16'h0001, 1'b0);
        settle_and_configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h8000_0000, 16'h7FFF, 1'b1);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 16'h8000, 1'b0);
        settle_and_configure(TIME_STEP_RESET, MOBILITY_RESET);

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin phase_idle = 0;  recv_stall_pct = 0;  end
                1: begin phase_idle = 52; recv_stall_pct = 0;  end
                2: begin phase_idle = 0;  recv_stall_pct = 52; end
                default: begin phase_idle = 27; recv_stall_pct = 27; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // short runs without idling inside the idle phases
                send_idle_pct = (n % 70 >= 35 && n % 70 < 50) ? 0 : phase_idle;
                if (phase == 0 && n == 100)
                    hold_request = 1'b1;
                random_particle();
            end
            case (phase)
                0: settle_and_configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1: settle_and_configure(0, 0);
                2: settle_and_configure($urandom, $urandom);
                default: ;
            endcase
        end

        // drain
        particle.valid <= 1'b0;
        recv_stall_pct = 0;
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d particles, checked %0d result words over four flow-control",
                 particles_sent, words_checked);
        $display("patterns, register extremes and one long output hold-off");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
sv/apes_pkg.sv
sv/apes_if.sv
sv/apes_cell.sv
sv/apes_tail.sv
sv/active_particle_euler_step.sv
tb/sv/particle_step_checker.sv
tb/sv/tb.sv
